// File: hw/rtl/itd_pkg.sv
package itd_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W = 6;
	localparam int CHAR_W = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_X = 7'h78;

	typedef struct packed {
		logic start;
		logic [RADIX_W-1:0] base;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [RADIX_W-1:0] rem;
	} div_rsp_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > 6'd9) begin
			c = CH_LOWER_A + CHAR_W'(d) - 7'd10;
		end else begin
			c = CH_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
		logic [CHAR_W-1:0] c;
		if (n > 4'd9) begin
			c = CH_UPPER_A + CHAR_W'(n) - 7'd10;
		end else begin
			c = CH_ZERO + CHAR_W'(n);
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/itd_div.sv
module itd_div #(
	parameter int VALUE_BITS = itd_pkg::VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  itd_pkg::div_req_t      req,
	input  logic [VALUE_BITS-1:0]  dividend,
	output itd_pkg::div_rsp_t      rsp,
	output logic [VALUE_BITS-1:0]  quotient
);
	import itd_pkg::*;

	localparam int CW = $clog2(VALUE_BITS + 1);

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] base_q;

	logic [RADIX_W:0]   trial;
	logic [RADIX_W:0]   diff;
	logic               ge;

	// one restoring step: shift in next dividend bit, subtract base if it fits
	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge = trial >= {1'b0, base_q};
	assign diff = trial - {1'b0, base_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CW'(VALUE_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			base_q <= req.base;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem = rem_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/integer_to_text.sv
// integer_to_text: renders one value as an ascii character stream.
// channels: cfg (cfg_valid/cfg_ready/cfg_data) writes the radix, always ready;
// in (in_valid/in_ready, func, value) takes one request; out (out_valid/out_ready,
// character, last) gives one character per beat, most significant first, last
// set on the final one.
// in_ready is high only while the block is idle; one request is in flight.
// radix mode: one shared restoring divider makes one quotient bit per cycle and
// one digit per division; after the digits comes a sign step, and each character
// is a digit buffer read followed by an output load.
// hex mode: 0x plus (VALUE_BITS+3)/4 digits, one character per cycle unless stalled.
// the output register parts the two sides: a stalled receiver holds character
// and last steady and holds the sequencer at its next character load; a new request may be taken while
// the final character still waits.
// reset: radix returns to 10, the sequencer to idle, out_valid drops; the digit
// buffer needs no clearing.
module integer_to_text #(
	parameter int VALUE_BITS = itd_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [itd_pkg::RADIX_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [VALUE_BITS-1:0]       value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [itd_pkg::CHAR_W-1:0]  character,
	output logic                        last
);
	import itd_pkg::*;

	localparam int DEPTH = VALUE_BITS + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
	localparam int HEX_W = HEX_DIGITS * 4;
	localparam int POS_W = $clog2(HEX_DIGITS + 2);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIV  = 6'b000010,
		S_SIGN = 6'b000100,
		S_RD   = 6'b001000,
		S_EMIT = 6'b010000,
		S_HEX  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [RADIX_W-1:0]   radix_q;
	logic                 neg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [HEX_W-1:0]     hex_sr_q;
	logic [POS_W-1:0]     pos_q;
	logic [RADIX_W-1:0]   rd_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    character_q;
	logic                 last_q;

	logic [RADIX_W-1:0]   dig_mem [DEPTH];

	logic                 in_acc;
	logic                 out_free;
	logic                 out_load;
	logic [RADIX_W-1:0]   base_eff;
	logic [VALUE_BITS-1:0] mag;
	logic [VALUE_BITS-1:0] quotient;
	logic [VALUE_BITS-1:0] dividend;
	logic [CNT_W-1:0]     cnt_dec;
	logic                 quo_zero;
	logic                 dig_we;
	logic                 dig_re;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cnt_dec = cnt_q - CNT_W'(1);
	assign quo_zero = (quotient == '0);

	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base_eff = RADIX_MAX;
		end else begin
			base_eff = radix_q;
		end
	end

	always_comb begin
		case (state_q)
			S_SIGN: out_load = neg_q && out_free;
			S_EMIT: out_load = out_free;
			S_HEX: out_load = out_free;
			default: out_load = 1'b0;
		endcase
	end

	assign mag = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
	assign dividend = (state_q == S_IDLE) ? mag : quotient;

	assign div_req.start = (in_acc && !func) ||
		(state_q == S_DIV && div_rsp.done && !quo_zero);
	assign div_req.base = base_eff;

	assign dig_we = (state_q == S_DIV) && div_rsp.done;
	assign dig_re = (state_q == S_RD);

	itd_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (dividend),
		.rsp      (div_rsp),
		.quotient (quotient)
	);

	// digit buffer, least significant digit first
	always_ff @(posedge clk) begin
		if (dig_we) begin
			dig_mem[cnt_q[AW-1:0]] <= div_rsp.rem;
		end
		if (dig_re) begin
			rd_q <= dig_mem[cnt_dec[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			pos_q <= '0;
			neg_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
						pos_q <= '0;
						neg_q <= value[VALUE_BITS-1];
						state_q <= func ? S_HEX : S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (quo_zero) begin
							state_q <= S_SIGN;
						end
					end
				end
				S_SIGN: begin
					if (!neg_q || out_free) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					cnt_q <= cnt_dec;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= (cnt_q == '0) ? S_IDLE : S_RD;
					end
				end
				S_HEX: begin
					if (out_free) begin
						pos_q <= pos_q + POS_W'(1);
						if (pos_q == POS_W'(HEX_DIGITS + 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output payload and hex shifter
	always_ff @(posedge clk) begin
		if (in_acc) begin
			hex_sr_q <= HEX_W'(value);
		end
		case (state_q)
			S_SIGN: begin
				if (neg_q && out_free) begin
					character_q <= CH_MINUS;
					last_q <= 1'b0;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					character_q <= digit_char(rd_q);
					last_q <= (cnt_q == '0);
				end
			end
			S_HEX: begin
				if (out_free) begin
					last_q <= (pos_q == POS_W'(HEX_DIGITS + 1));
					if (pos_q == '0) begin
						character_q <= CH_ZERO;
					end else if (pos_q == POS_W'(1)) begin
						character_q <= CH_X;
					end else begin
						character_q <= hex_char(hex_sr_q[HEX_W-1 -: 4]);
						hex_sr_q <= {hex_sr_q[HEX_W-5:0], 4'h0};
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last = last_q;

endmodule

// File: hw/rtl/itd_checker.sv
module itd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] character,
	input logic       last
);

	// one request in flight: ready drops right after a request is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready still high after a request was taken");

	// a stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(character) && $stable(last)))
		else $error("stalled character changed");

	// every character is between '-' and 'z'
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character >= 7'h2D && character <= 7'h7A))
		else $error("character out of range");

	// while idle, only the final character of the previous text may wait
	a_idle_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && out_valid) |-> last)
		else $error("idle with a non-final character pending");

endmodule

bind integer_to_text itd_checker u_itd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.character (character),
	.last      (last)
);
